// File: src/matrix_multiply_defines.svh
`ifndef MATRIX_MULTIPLY_DEFINES_SVH
`define MATRIX_MULTIPLY_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define MM_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MM_ASSERT(label, clk, rst, prop)
`define MM_ASSERT_NR(label, clk, prop)
`endif
`endif

// File: src/mm_pkg.sv
package mm_pkg;
   localparam int MaxDim   = 8;
   localparam int ElemBits = 16;
   localparam int IdxW     = $clog2(MaxDim);
   localparam int SizeW    = 4;
   localparam int AccW     = 40;
   localparam int ChainLat = 2 * MaxDim;
   localparam int DrainW   = $clog2(ChainLat);

   typedef enum logic [1:0] {
      CMD_WRITE_A = 2'd0,
      CMD_WRITE_B = 2'd1,
      CMD_COMPUTE = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   localparam logic [1:0] REG_ROWS  = 2'd0;
   localparam logic [1:0] REG_INNER = 2'd1;
   localparam logic [1:0] REG_COLS  = 2'd2;

   typedef struct packed {
      logic             valid;
      logic             last;
      logic [IdxW-1:0]  row;
      logic [IdxW-1:0]  col;
   } tag_type;

   function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v);
      logic [SizeW-1:0] r;
      r = v;
      if (v == '0) r = SizeW'(1);
      else if (v > SizeW'(MaxDim)) r = SizeW'(MaxDim);
      return r;
   endfunction
endpackage

// File: src/matrix_multiply.sv
// Dense matrix product C = A x B, signed Q8.8 elements in, exact Q24.16 sums out.
// A write command is taken while idle and busy stays low. A compute command
// keeps busy high while its elements are issued and drained: one product
// element enters the chain of cells per cycle and passes through the register
// stages of each of the eight cells on its way out. Results appear on
// rsp_valid for one cycle each, in row-major order; the receiver cannot stall,
// and no new word is taken until the last result is out.
`include "matrix_multiply_defines.svh"
module matrix_multiply import mm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_command,
   input  logic [IdxW-1:0]     req_row_index,
   input  logic [IdxW-1:0]     req_col_index,
   input  logic signed [15:0]  req_element_value,
   output logic                rsp_valid,
   output logic [IdxW-1:0]     rsp_out_row,
   output logic [IdxW-1:0]     rsp_out_col,
   output logic signed [AccW-1:0] rsp_out_value,
   output logic                rsp_last_of_run,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [3:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   state_type st_ff, st_in;
   logic [SizeW-1:0]  rows_ff, inner_ff, cols_ff, m, n, k;
   logic [IdxW-1:0]   i_ff, i_in, j_ff, j_in;
   logic [DrainW-1:0] drain_ff, drain_in;
   logic              acc, issue, lastp, row_end, col_end, wr_a, wr_b;
   cmd_type           cmd;
   tag_type           tag_in, tag_out;
   logic signed [AccW-1:0] value_out;

   assign cmd    = cmd_type'(req_command);
   assign acc    = start && !busy;
   assign pready = 1'b1;
   assign m = clamp_size(rows_ff);
   assign n = clamp_size(inner_ff);
   assign k = clamp_size(cols_ff);
   assign wr_a = acc && cmd == CMD_WRITE_A;
   assign wr_b = acc && cmd == CMD_WRITE_B;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= SizeW'(MaxDim); inner_ff <= SizeW'(MaxDim); cols_ff <= SizeW'(MaxDim);
      end else if (psel && penable && pwrite && pready) begin
         unique case (paddr[3:2])
            REG_ROWS:  rows_ff  <= pwdata[SizeW-1:0];
            REG_INNER: inner_ff <= pwdata[SizeW-1:0];
            REG_COLS:  cols_ff  <= pwdata[SizeW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_ROWS:  prdata = 32'(rows_ff);
         REG_INNER: prdata = 32'(inner_ff);
         REG_COLS:  prdata = 32'(cols_ff);
         default:   prdata = '0;
      endcase
   end

   assign col_end = SizeW'(j_ff) == k - SizeW'(1);
   assign row_end = SizeW'(i_ff) == m - SizeW'(1);

   always_comb begin
      st_in = st_ff; i_in = i_ff; j_in = j_ff; drain_in = drain_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (acc && cmd == CMD_COMPUTE) begin
               st_in = ST_RUN; i_in = '0; j_in = '0;
            end
         end
         ST_RUN: begin
            if (col_end) begin
               j_in = '0;
               if (row_end) begin
                  st_in = ST_DRAIN;
                  drain_in = DrainW'(ChainLat - 1);
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff - 1'b1;
            if (drain_ff == '0) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy  = st_ff != ST_IDLE;
      issue = st_ff == ST_RUN;
      lastp = issue && row_end && col_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; i_ff <= '0; j_ff <= '0; drain_ff <= '0;
      end else begin
         st_ff <= st_in; i_ff <= i_in; j_ff <= j_in; drain_ff <= drain_in;
      end
   end

   always_comb begin
      tag_in.valid = issue;
      tag_in.last  = lastp;
      tag_in.row   = i_ff;
      tag_in.col   = j_ff;
   end

   mm_chain u_chain (
      .clock(clock), .reset(reset), .inner(n),
      .wr_a(wr_a), .wr_b(wr_b), .wr_row(req_row_index), .wr_col(req_col_index),
      .wr_data(ElemBits'(req_element_value)),
      .tag_in(tag_in), .tag_out(tag_out), .value_out(value_out)
   );

   assign rsp_valid       = tag_out.valid;
   assign rsp_out_row     = tag_out.row;
   assign rsp_out_col     = tag_out.col;
   assign rsp_out_value   = value_out;
   assign rsp_last_of_run = tag_out.last;

   `MM_ASSERT(a_rsp_busy, clock, reset, rsp_valid |-> busy)
   `MM_ASSERT(a_last_idle, clock, reset, rsp_valid && rsp_last_of_run |=> !busy && !rsp_valid)
   `MM_ASSERT(a_state_legal, clock, reset, st_ff == ST_IDLE || st_ff == ST_RUN || st_ff == ST_DRAIN)
   `MM_ASSERT_NR(a_pready, clock, pready)
endmodule

// File: src/mm_cell.sv
module mm_cell import mm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cell_on,
   input  logic                       wr_a,
   input  logic                       wr_b,
   input  logic [IdxW-1:0]            wr_index,
   input  logic signed [ElemBits-1:0] wr_data,
   input  tag_type                    tag_left,
   input  logic signed [AccW-1:0]     sum_left,
   output tag_type                    tag_right,
   output logic signed [AccW-1:0]     sum_right
);
   logic signed [ElemBits-1:0]   mem_a [MaxDim];
   logic signed [ElemBits-1:0]   mem_b [MaxDim];
   logic signed [ElemBits-1:0]   a_rd_ff, b_rd_ff;
   logic signed [2*ElemBits-1:0] prod;
   logic signed [AccW-1:0]       sum1_ff, sum2_ff, sum2_in;
   tag_type                      tag1_ff, tag2_ff;

   // column of A and row of B for this inner index
   always_ff @(posedge clock) begin
      if (wr_a) mem_a[wr_index] <= wr_data;
      if (wr_b) mem_b[wr_index] <= wr_data;
   end

   always_comb begin
      prod    = a_rd_ff * b_rd_ff;
      sum2_in = cell_on ? sum1_ff + AccW'(prod) : sum1_ff;
   end

   always_ff @(posedge clock) begin
      a_rd_ff <= mem_a[tag_left.row];
      b_rd_ff <= mem_b[tag_left.col];
      sum1_ff <= sum_left;
      sum2_ff <= sum2_in;
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else begin
         tag1_ff <= tag_left;
         tag2_ff <= tag1_ff;
      end
   end

   assign tag_right = tag2_ff;
   assign sum_right = sum2_ff;
endmodule

// File: src/mm_chain.sv
module mm_chain import mm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [SizeW-1:0]           inner,
   input  logic                       wr_a,
   input  logic                       wr_b,
   input  logic [IdxW-1:0]            wr_row,
   input  logic [IdxW-1:0]            wr_col,
   input  logic signed [ElemBits-1:0] wr_data,
   input  tag_type                    tag_in,
   output tag_type                    tag_out,
   output logic signed [AccW-1:0]     value_out
);
   tag_type                tags [MaxDim+1];
   logic signed [AccW-1:0] sums [MaxDim+1];
   logic [IdxW-1:0]        wr_index;

   assign tags[0]  = tag_in;
   assign sums[0]  = '0;
   assign wr_index = wr_a ? wr_row : wr_col;

   for (genvar t = 0; t < MaxDim; t++) begin : g_cell
      logic cell_on, cell_wr_a, cell_wr_b;

      assign cell_on   = SizeW'(t) < inner;
      assign cell_wr_a = wr_a && wr_col == IdxW'(t);
      assign cell_wr_b = wr_b && wr_row == IdxW'(t);

      mm_cell u_cell (
         .clock(clock), .reset(reset), .cell_on(cell_on),
         .wr_a(cell_wr_a), .wr_b(cell_wr_b), .wr_index(wr_index), .wr_data(wr_data),
         .tag_left(tags[t]), .sum_left(sums[t]),
         .tag_right(tags[t+1]), .sum_right(sums[t+1])
      );
   end

   assign tag_out   = tags[MaxDim];
   assign value_out = sums[MaxDim];
endmodule
